/* design/pema_pkg.sv */
package pema_pkg;

  // Field widths
  localparam int unsigned PosW     = 32;
  localparam int unsigned AlphaW   = 17;
  localparam int unsigned JumpW    = 31;
  localparam int unsigned LimSqW   = 2 * JumpW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef logic signed [PosW-1:0]   pos_t;
  typedef logic        [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic        [CfgDataW-1:0] cfg_data_t;

  // Register indexes on the config port
  localparam cfg_idx_t CfgIdxEnable  = 2'd0;
  localparam cfg_idx_t CfgIdxAlpha   = 2'd1;
  localparam cfg_idx_t CfgIdxJumpLim = 2'd2;

  // Q1.16 unity weight
  localparam logic [AlphaW-1:0] AlphaOne = 17'd65536;

  // Register reset values
  localparam logic [AlphaW-1:0] AlphaRst   = 17'd6554;
  localparam logic [JumpW-1:0]  JumpLimRst = 31'd9830;
  localparam logic [LimSqW-1:0] LimSqRst   = LimSqW'(JumpLimRst) * LimSqW'(JumpLimRst);

endpackage

/* design/pema_intf.sv */
// Position sample channel
interface pema_pos_if
  import pema_pkg::*;
();
  logic valid;
  logic ready;
  pos_t pos_x;
  pos_t pos_y;
  pos_t pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// Filtered position channel
interface pema_filt_if
  import pema_pkg::*;
();
  logic valid;
  logic ready;
  pos_t filt_x;
  pos_t filt_y;
  pos_t filt_z;

  modport source (output valid, output filt_x, output filt_y, output filt_z, input ready);
  modport sink   (input valid, input filt_x, input filt_y, input filt_z, output ready);
endinterface

// Register write channel
interface pema_cfg_if
  import pema_pkg::*;
();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/pose_ema_with_jump_reset_unit.sv */
// Position smoother with outlier snap.
// A sample is held in the input register and then in the result register, which drives the output.
// Throughput: one sample per cycle while the output is not stalled; the estimate loop is
// combinational through the difference, the alpha and distance multipliers and the snap select.
// Reset: registers return to enable=0, alpha=6554, jump limit=9830; estimate and primed
// flag clear; both stages empty. Config writes are taken in every cycle.
module pose_ema_with_jump_reset_unit
  import pema_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  pema_cfg_if.sink     cfg_i,
  pema_pos_if.sink     pos_i,
  pema_filt_if.source  filt_o
);

  // Config registers
  logic              enable_q;
  logic [AlphaW-1:0] alpha_q;
  logic [JumpW-1:0]  jump_q;
  logic [LimSqW-1:0] lim_sq_q;
  logic              cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      alpha_q  <= AlphaRst;
      jump_q   <= JumpLimRst;
      lim_sq_q <= LimSqRst;
    end else if (cfg_wr) begin
      case (cfg_i.index)
        CfgIdxEnable:  enable_q <= cfg_i.data[0];
        CfgIdxAlpha:   alpha_q  <= cfg_i.data[AlphaW-1:0];
        CfgIdxJumpLim: begin
          jump_q   <= cfg_i.data[JumpW-1:0];
          // squared limit kept ready so the loop only compares
          lim_sq_q <= LimSqW'(cfg_i.data[JumpW-1:0]) * LimSqW'(cfg_i.data[JumpW-1:0]);
        end
        default: ;
      endcase
    end
  end

  // Handshake between input stage and result stage
  logic s_vld_q, o_vld_q;
  logic in_beat, adv;

  assign adv         = s_vld_q && (!o_vld_q || filt_o.ready);
  assign pos_i.ready = !s_vld_q || adv;
  assign in_beat     = pos_i.valid && pos_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (in_beat)  s_vld_q <= 1'b1;
      else if (adv) s_vld_q <= 1'b0;
      if (adv)               o_vld_q <= 1'b1;
      else if (filt_o.ready) o_vld_q <= 1'b0;
    end
  end

  // Input sample register
  pos_t smp_q [3];

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      smp_q[0] <= pos_i.pos_x;
      smp_q[1] <= pos_i.pos_y;
      smp_q[2] <= pos_i.pos_z;
    end
  end

  // Filter state
  logic primed_q, primed_d;
  pos_t est_q [3];
  pos_t est_d [3];
  pos_t res_d [3];
  pos_t res_q [3];

  // Per-axis update
  logic [AlphaW-1:0]       a_sat;
  logic signed [PosW:0]    dif   [3];
  logic [PosW:0]           mag   [3];
  logic [LimSqW-1:0]       sq    [3];
  logic signed [PosW+AlphaW+1:0] prod [3];
  logic signed [PosW+2:0]  step  [3];
  logic signed [PosW+2:0]  moved [3];
  logic [LimSqW+1:0]       dist2;
  logic                    over, snap;

  assign a_sat = alpha_q[AlphaW-1] ? AlphaOne : alpha_q;

  always_comb begin
    over = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dif[i]   = {smp_q[i][PosW-1], smp_q[i]} - {est_q[i][PosW-1], est_q[i]};
      mag[i]   = dif[i][PosW] ? (PosW+1)'(-dif[i]) : (PosW+1)'(dif[i]);
      over     = over || (mag[i] > (PosW+1)'(jump_q));
      sq[i]    = LimSqW'(mag[i][JumpW-1:0]) * LimSqW'(mag[i][JumpW-1:0]);
      prod[i]  = $signed({1'b0, a_sat}) * dif[i];
      // floor of product / 2^16
      step[i]  = prod[i][PosW+AlphaW+1:16];
      moved[i] = (PosW+3)'(est_q[i]) + step[i];
    end
    dist2 = (LimSqW+2)'(sq[0]) + (LimSqW+2)'(sq[1]) + (LimSqW+2)'(sq[2]);
    snap  = (jump_q != '0) && (over || (dist2 > (LimSqW+2)'(lim_sq_q)));
  end

  always_comb begin
    primed_d = primed_q;
    for (int i = 0; i < 3; i++) begin
      est_d[i] = est_q[i];
      res_d[i] = smp_q[i];
    end
    if (!enable_q) begin
      primed_d = 1'b0;
    end else begin
      primed_d = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (!primed_q || snap) est_d[i] = smp_q[i];
        else                   est_d[i] = moved[i][PosW-1:0];
        res_d[i] = est_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      for (int i = 0; i < 3; i++) est_q[i] <= '0;
    end else if (adv) begin
      primed_q <= primed_d;
      for (int i = 0; i < 3; i++) est_q[i] <= est_d[i];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) res_q[i] <= res_d[i];
    end
  end

  assign filt_o.valid  = o_vld_q;
  assign filt_o.filt_x = res_q[0];
  assign filt_o.filt_y = res_q[1];
  assign filt_o.filt_z = res_q[2];

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb
  import pema_pkg::*;
();

  // Index with no register behind it; writes to it must change nothing
  localparam cfg_idx_t CfgIdxUnused = 2'd3;
  localparam pos_t PosMax = 32'sh7FFF_FFFF;
  localparam pos_t PosMin = 32'sh8000_0000;
  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
  } xyz_t;

  typedef struct packed {
    cfg_idx_t  idx;
    cfg_data_t data;
  } reg_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pema_cfg_if  cfg_if ();
  pema_pos_if  pos_if ();
  pema_filt_if filt_if ();

  pose_ema_with_jump_reset_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pos_i  (pos_if),
    .filt_o (filt_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus and expectation stores
  reg_write_t reg_q[$];
  xyz_t       sample_q[$];
  xyz_t       filt_expect_q[$];

  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  int  hold_req      = 0;
  int  hold_seen     = 0;
  int  hold_left     = 0;
  int  err_cnt       = 0;
  int  quiet_cycles  = 0;
  bit  cfg_beat;
  bit  pos_beat;

  // Shadow of the filter registers and state
  bit                flt_enable   = 1'b0;
  logic [AlphaW-1:0] flt_alpha    = AlphaRst;
  logic [JumpW-1:0]  flt_jump_lim = JumpLimRst;
  bit                flt_primed   = 1'b0;
  xyz_t              flt_est      = '0;

  function automatic void apply_reg_write(cfg_idx_t idx, cfg_data_t data);
    case (idx)
      CfgIdxEnable:  flt_enable = data[0];
      CfgIdxAlpha:   flt_alpha = data[AlphaW-1:0];
      CfgIdxJumpLim: flt_jump_lim = data[JumpW-1:0];
      default: ;
    endcase
  endfunction

  // est + floor(a * (smp - est) / 2^16), exact product
  function automatic pos_t ema_toward(pos_t est, pos_t smp, logic [AlphaW-1:0] a);
    longint d;
    longint p;
    d = longint'(smp) - longint'(est);
    p = longint'(a) * d;
    return pos_t'(longint'(est) + (p >>> 16));
  endfunction

  function automatic xyz_t predict_filtered(xyz_t smp);
    logic [AlphaW-1:0] a;
    longint            dx, dy, dz;
    logic [63:0]       ax, ay, az, lim;
    logic [65:0]       dist_sq, lim_sq;
    bit                snap;
    // disabled: pass through, forget priming, keep estimate
    if (!flt_enable) begin
      flt_primed = 1'b0;
      return smp;
    end
    if (!flt_primed) begin
      flt_est    = smp;
      flt_primed = 1'b1;
      return flt_est;
    end
    a    = (flt_alpha > AlphaOne) ? AlphaOne : flt_alpha;
    snap = 1'b0;
    if (flt_jump_lim != '0) begin
      dx  = longint'(smp.x) - longint'(flt_est.x);
      dy  = longint'(smp.y) - longint'(flt_est.y);
      dz  = longint'(smp.z) - longint'(flt_est.z);
      ax  = (dx < 0) ? -dx : dx;
      ay  = (dy < 0) ? -dy : dy;
      az  = (dz < 0) ? -dz : dz;
      lim = 64'(flt_jump_lim);
      dist_sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay) + 66'(az) * 66'(az);
      lim_sq  = 66'(lim) * 66'(lim);
      snap = (dist_sq > lim_sq);
    end
    if (snap) begin
      flt_est = smp;
    end else begin
      flt_est.x = ema_toward(flt_est.x, smp.x, a);
      flt_est.y = ema_toward(flt_est.y, smp.y, a);
      flt_est.z = ema_toward(flt_est.z, smp.z, a);
    end
    return flt_est;
  endfunction

  // Sample all channels at the rising edge
  always @(posedge clk_i) begin : sampler
    xyz_t got;
    xyz_t want;
    xyz_t smp;
    cfg_beat = 1'b0;
    pos_beat = 1'b0;
    if (rst_ni) begin
      cfg_beat = cfg_if.valid && cfg_if.ready;
      pos_beat = pos_if.valid && pos_if.ready;
      if (cfg_beat) begin
        apply_reg_write(cfg_if.index, cfg_if.data);
      end
      if (pos_beat) begin
        smp.x = pos_if.pos_x;
        smp.y = pos_if.pos_y;
        smp.z = pos_if.pos_z;
        filt_expect_q.push_back(predict_filtered(smp));
      end
      if (filt_if.valid && filt_if.ready) begin
        got.x = filt_if.filt_x;
        got.y = filt_if.filt_y;
        got.z = filt_if.filt_z;
        if (filt_expect_q.size() == 0) begin
          $error("filtered beat with nothing expected: x=%0d y=%0d z=%0d",
                 got.x, got.y, got.z);
          err_cnt++;
        end else begin
          want = filt_expect_q.pop_front();
          if (got.x !== want.x) begin
            $error("filt_x: expected %0d, got %0d", want.x, got.x);
            err_cnt++;
          end
          if (got.y !== want.y) begin
            $error("filt_y: expected %0d, got %0d", want.y, got.y);
            err_cnt++;
          end
          if (got.z !== want.z) begin
            $error("filt_z: expected %0d, got %0d", want.z, got.z);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: cycles without any beat on any channel
  always @(posedge clk_i) begin
    if (cfg_if.valid && cfg_if.ready || pos_if.valid && pos_if.ready ||
        filt_if.valid && filt_if.ready) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("pose_ema_with_jump_reset_unit test failed");
      $finish;
    end
  end

  // Register write driver
  always @(negedge clk_i) begin : reg_driver
    reg_write_t w;
    if (!cfg_if.valid || cfg_beat) begin
      if (reg_q.size() != 0) begin
        w = reg_q.pop_front();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= w.idx;
        cfg_if.data  <= w.data;
      end else begin
        cfg_if.valid <= 1'b0;
      end
    end
  end

  // Sample driver, idles at random
  always @(negedge clk_i) begin : sample_driver
    xyz_t s;
    if (!pos_if.valid || pos_beat) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s = sample_q.pop_front();
        pos_if.valid <= 1'b1;
        pos_if.pos_x <= s.x;
        pos_if.pos_y <= s.y;
        pos_if.pos_z <= s.z;
      end else begin
        pos_if.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls plus a long hold-off on request
  always @(negedge clk_i) begin : ready_driver
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      filt_if.ready <= 1'b0;
    end else begin
      filt_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic program_reg(cfg_idx_t idx, cfg_data_t data);
    reg_q.push_back('{idx: idx, data: data});
    while (reg_q.size() != 0 || cfg_if.valid) @(posedge clk_i);
  endtask

  task automatic push_sample(pos_t x, pos_t y, pos_t z);
    sample_q.push_back('{x: x, y: y, z: z});
  endtask

  // Wait until every sample is in and every result is out, then let the pipe empty
  task automatic drain_samples();
    while (sample_q.size() != 0 || pos_if.valid || filt_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    xyz_t             track;
    cfg_data_t        dat;
    logic [JumpW-1:0] lim_eff;
    int               scale;
    int               step;
    int               pick;

    rst_ni        = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CfgIdxEnable;
    cfg_if.data   = '0;
    pos_if.valid  = 1'b0;
    pos_if.pos_x  = '0;
    pos_if.pos_y  = '0;
    pos_if.pos_z  = '0;
    filt_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Disabled after reset: straight pass-through, all bit extremes
    push_sample(PosMax, PosMin, 32'sd0);
    push_sample(PosMin, PosMax, -32'sd1);
    push_sample(32'sh5555_5555, 32'shAAAA_AAAA, 32'sd0);
    push_sample(-32'sd1, 32'sd0, PosMax);
    drain_samples();

    // Enable with upper data bits set; alpha above one saturates; guard off
    program_reg(CfgIdxEnable, 32'hFFFF_FFFF);
    program_reg(CfgIdxAlpha, 32'hFFFF_FFFF);
    program_reg(CfgIdxJumpLim, 32'h0000_0000);
    push_sample(PosMin, PosMin, PosMin);
    push_sample(PosMax, PosMax, PosMax);
    push_sample(32'sd0, -32'sd1, 32'sd1);
    drain_samples();

    // One disabled sample clears priming
    program_reg(CfgIdxEnable, 32'hFFFF_FFFE);
    program_reg(CfgIdxUnused, 32'hFFFF_FFFF);
    push_sample(32'sd7, 32'sd7, 32'sd7);
    drain_samples();

    // Frozen estimate (alpha zero) to probe the distance test at the limit
    program_reg(CfgIdxEnable, 32'h0000_0001);
    program_reg(CfgIdxAlpha, 32'h0000_0000);
    program_reg(CfgIdxJumpLim, 32'h0000_0003);
    push_sample(32'sd0, 32'sd0, 32'sd0);
    push_sample(32'sd3, 32'sd0, 32'sd0);
    push_sample(32'sd2, 32'sd2, 32'sd1);
    push_sample(32'sd2, 32'sd2, 32'sd2);
    push_sample(32'sd2, 32'sd2, -32'sd1);
    push_sample(32'sd6, 32'sd2, 32'sd2);
    drain_samples();

    // Widest limit, nearly unit weight, full-scale swings
    program_reg(CfgIdxAlpha, 32'h0000_FFFF);
    program_reg(CfgIdxJumpLim, 32'hFFFF_FFFF);
    push_sample(PosMin, PosMin, PosMin);
    push_sample(PosMax, PosMax, PosMax);
    push_sample(PosMax - 32'sd5, PosMax, PosMax);
    drain_samples();

    // Smallest nonzero weight: floor rounding on both signs
    program_reg(CfgIdxAlpha, 32'h0000_0001);
    program_reg(CfgIdxJumpLim, 32'h0001_0000);
    push_sample(PosMax - 32'sd105, PosMax, PosMax);
    push_sample(PosMax, PosMax - 32'sd100, PosMax);
    drain_samples();

    // Random phases: tracked motion with noise and jumps under varied settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 80; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase

      dat    = $urandom;
      dat[0] = ($urandom_range(99) < 85);
      program_reg(CfgIdxEnable, dat);

      case ($urandom_range(5))
        0: dat = 32'd0;
        1: dat = 32'(AlphaOne);
        2: dat = $urandom_range(131071, 65537);
        3: dat = $urandom;
        default: dat = $urandom_range(65535, 1);
      endcase
      program_reg(CfgIdxAlpha, dat);

      case ($urandom_range(5))
        0: dat = 32'd0;
        1: dat = $urandom_range(255, 1);
        2: dat = $urandom_range(1 << 20, 256);
        3: dat = 32'h7FFF_FFFF;
        4: dat = $urandom;
        default: dat = $urandom_range(1 << 24, 1 << 16);
      endcase
      program_reg(CfgIdxJumpLim, dat);
      lim_eff = dat[JumpW-1:0];
      if ($urandom_range(3) == 0) begin
        program_reg(CfgIdxUnused, $urandom);
      end

      if (lim_eff == '0) begin
        scale = 1 << 16;
      end else if (lim_eff > (1 << 24)) begin
        scale = 1 << 24;
      end else begin
        scale = int'(lim_eff);
      end

      track.x = $urandom;
      track.y = $urandom;
      track.z = $urandom;
      for (int n = 0; n < 125; n++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          // outlier that does not move the track
          push_sample($urandom, $urandom, $urandom);
        end else begin
          if (pick < 15) begin
            track.x = $urandom;
            track.y = $urandom;
            track.z = $urandom;
          end else begin
            step = ($urandom_range(3) == 0) ? scale / 4 : scale;
            track.x = track.x + pos_t'(int'($urandom_range(2 * step)) - step);
            track.y = track.y + pos_t'(int'($urandom_range(2 * step)) - step);
            track.z = track.z + pos_t'(int'($urandom_range(2 * step)) - step);
          end
          push_sample(track.x, track.y, track.z);
        end
      end
      // hold results back while the sender keeps offering
      if (ph == 4) begin
        hold_req++;
      end
      drain_samples();
    end

    if (err_cnt == 0) begin
      $display("pose_ema_with_jump_reset_unit test passed");
    end else begin
      $display("pose_ema_with_jump_reset_unit test failed");
    end
    $finish;
  end

endmodule
